### sv/sandpile_relax_irregular_marked_sink_defines.svh
// Assertion macros used by the sandpile relaxation controller.
`ifndef SANDPILE_RELAX_IRREGULAR_MARKED_SINK_DEFINES_SVH
`define SANDPILE_RELAX_IRREGULAR_MARKED_SINK_DEFINES_SVH

// Implication check, disabled while in reset.
`define SRS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled while in reset.
`define SRS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/srs_pkg.sv
// Package: types, constants and codes for the sandpile relaxation block.
`timescale 1ns / 1ps
package srs_pkg;

  localparam int unsigned MaxRowsDef    = 32;
  localparam int unsigned MaxColsDef    = 32;
  localparam int unsigned HeightBitsDef = 32;

  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindRelax = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  localparam logic [1:0] CfgRows  = 2'd0;
  localparam logic [1:0] CfgCols  = 2'd1;
  localparam logic [1:0] CfgLimit = 2'd2;

  localparam logic [5:0]  RowsReset  = 6'd32;
  localparam logic [5:0]  ColsReset  = 6'd32;
  localparam logic [19:0] LimitReset = 20'd65535;

  // direction mask bits
  localparam int unsigned DirRight = 0;
  localparam int unsigned DirLeft  = 1;
  localparam int unsigned DirDown  = 2;
  localparam int unsigned DirUp    = 3;
  localparam int unsigned DirDnRt  = 4;
  localparam int unsigned DirUpLt  = 5;
  localparam int unsigned NumDirs  = 6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] height;
    logic [5:0]  degree;
    logic [5:0]  directions;
    logic        sink_flag;
  } in_word_t;

  typedef struct packed {
    logic [31:0] cell_height;
    logic [19:0] sweeps_done;
    logic        not_stable;
    logic        overflow;
  } out_word_t;

  // attribute word: sink, degree, mask
  typedef struct packed {
    logic       sink;
    logic [5:0] degree;
    logic [5:0] dirs;
  } attr_t;

  // controller -> datapath commands
  typedef struct packed {
    logic cap_item;     // latch input word
    logic do_write;     // write cell from latched word
    logic rd_issue;     // read address = latched cell
    logic sw_start;     // start a new sweep at (1,1)
    logic cell_rd;      // read current scan cell
    logic div_start;    // start divider on read cell
    logic nb_rd;        // read neighbor (dir in dp)
    logic nb_wr;        // write neighbor with added pile
    logic self_wr;      // write remainder to current cell
    logic scan_next;    // step interior scan
    logic zr_start;     // start zeroing pass at (0,0)
    logic zr_rd;        // read attr at zero pointer
    logic zr_wr;        // zero cell if needed, step
    logic res_relax;    // build relax result
    logic res_other;    // build write/read result
  } cmd_t;

  typedef struct packed {
    logic       topple;      // read cell topples
    logic       div_done;
    logic       nb_first;    // toppling cell feeds at least one neighbor
    logic       nb_any;      // another selected direction remains
    logic       scan_last;   // scan pointer at last interior cell
    logic       no_interior;
    logic       no_cells;    // grid in use is empty
    logic       zr_last;
    logic       sweep_more;  // changed and below limit
  } sts_t;

endpackage

### sv/srs_div.sv
// Restoring divider: wide height by a six-bit degree, one quotient bit a cycle.
`timescale 1ns / 1ps
module srs_div import srs_pkg::*; #(
  parameter int unsigned HeightBits = HeightBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [HeightBits-1:0] dividend_i,
  input  logic [5:0]            divisor_i,
  output logic                  done_o,
  output logic [HeightBits-1:0] quot_o,
  output logic [5:0]            rem_o
);
  localparam int unsigned CntW = $clog2(HeightBits + 1);

  logic [HeightBits-1:0] quot_q, quot_d;
  logic [6:0]            rem_q, rem_d;
  logic [5:0]            dvs_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [6:0]            trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[5:0], quot_q[HeightBits-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(HeightBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
      end else begin
        rem_d = trial;
      end
      quot_d = {quot_q[HeightBits-2:0], (trial >= {1'b0, dvs_q})};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quot_d;
  assign rem_o  = rem_d[5:0];
endmodule

### sv/srs_datapath.sv
// Datapath: cell memories, scan pointers, divider, saturating adds and results.
`timescale 1ns / 1ps
module srs_datapath import srs_pkg::*; #(
  parameter int unsigned MaxRows    = MaxRowsDef,
  parameter int unsigned MaxCols    = MaxColsDef,
  parameter int unsigned HeightBits = HeightBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_word_t out_word_o
);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned ColW  = $clog2(MaxCols);
  localparam int unsigned AddrW = RowW + ColW;
  localparam int unsigned Cells = 1 << AddrW;
  localparam logic [HeightBits-1:0] HMax = '1;

  logic [HeightBits-1:0] hmem [Cells];
  attr_t                 amem [Cells];

  logic [5:0]  rows_q, cols_q;
  logic [19:0] limit_q;
  in_word_t    item_q;
  logic        ovf_q, ovf_d;

  // effective grid bounds, clamped to the array size
  logic [8:0] nr, nc;
  logic       in_grid;
  assign nr = ({3'b0, rows_q} > 9'(MaxRows)) ? 9'(MaxRows) : {3'b0, rows_q};
  assign nc = ({3'b0, cols_q} > 9'(MaxCols)) ? 9'(MaxCols) : {3'b0, cols_q};
  assign in_grid = (32'(item_q.row) < MaxRows) && (32'(item_q.col) < MaxCols);

  logic [RowW-1:0] sr_q, sr_d;     // scan / zero row
  logic [ColW-1:0] sc_q, sc_d;
  logic [2:0]      dir_q, dir_d;
  logic [19:0]     sweeps_q, sweeps_d;
  logic            chg_q, chg_d;
  attr_t           cur_attr_q;
  logic [HeightBits-1:0] rd_h_q;
  attr_t           rd_a_q;
  logic [HeightBits-1:0] pile_q;
  logic [5:0]      rem_q;

  logic [RowW-1:0] nbr;
  logic [ColW-1:0] nbc;
  logic [AddrW-1:0] rd_addr, wr_addr, cur_addr, item_addr;
  logic [HeightBits-1:0] wr_h;
  logic             h_we, a_we;
  logic [HeightBits:0] sum;
  logic [HeightBits-1:0] item_h;
  logic             item_ovf;

  logic             div_done;
  logic [HeightBits-1:0] quot;
  logic [5:0]       rem;

  srs_div #(.HeightBits(HeightBits)) u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(rd_h_q),
    .divisor_i (cur_attr_q.degree),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // neighbor offsets per direction
  always_comb begin
    nbr = sr_q;
    nbc = sc_q;
    unique case (dir_q)
      3'(DirRight): nbc = sc_q + 1'b1;
      3'(DirLeft):  nbc = sc_q - 1'b1;
      3'(DirDown):  nbr = sr_q + 1'b1;
      3'(DirUp):    nbr = sr_q - 1'b1;
      3'(DirDnRt): begin nbr = sr_q + 1'b1; nbc = sc_q + 1'b1; end
      3'(DirUpLt): begin nbr = sr_q - 1'b1; nbc = sc_q - 1'b1; end
      default: ;
    endcase
  end

  // first selected direction at or after a given one
  function automatic logic [3:0] next_dir(input logic [5:0] m, input logic [2:0] from);
    logic [3:0] r;
    r = 4'd8;
    for (int i = NumDirs - 1; i >= 0; i--) begin
      if (m[i] && (3'(i) >= from)) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  logic [3:0] nd_first, nd_after;
  assign nd_first = next_dir(cur_attr_q.dirs, 3'd0);
  assign nd_after = next_dir(cur_attr_q.dirs, dir_q + 3'd1);

  assign cur_addr  = {sr_q, sc_q};
  assign item_addr = {RowW'(item_q.row), ColW'(item_q.col)};
  assign item_h    = (item_q.height > 32'(HMax)) ? HMax : HeightBits'(item_q.height);
  assign item_ovf  = item_q.height > 32'(HMax);
  assign sum       = {1'b0, rd_h_q} + {1'b0, pile_q};

  always_comb begin
    rd_addr = cur_addr;
    if (cmd_i.rd_issue) begin
      rd_addr = item_addr;
    end else if (cmd_i.nb_rd) begin
      rd_addr = {nbr, nbc};
    end
    h_we    = 1'b0;
    a_we    = 1'b0;
    wr_addr = cur_addr;
    wr_h    = '0;
    if (cmd_i.do_write && in_grid) begin
      h_we    = 1'b1;
      a_we    = 1'b1;
      wr_addr = item_addr;
      wr_h    = item_h;
    end else if (cmd_i.nb_wr) begin
      h_we    = 1'b1;
      wr_addr = {nbr, nbc};
      wr_h    = sum[HeightBits] ? HMax : sum[HeightBits-1:0];
    end else if (cmd_i.self_wr) begin
      h_we = 1'b1;
      wr_h = HeightBits'(rem_q);
    end else if (cmd_i.zr_wr) begin
      h_we = (rd_a_q.degree == 6'd0) || rd_a_q.sink;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hmem[wr_addr] <= wr_h;
    if (a_we) amem[wr_addr] <= {item_q.sink_flag, item_q.degree, item_q.directions};
    rd_h_q <= hmem[rd_addr];
    rd_a_q <= amem[rd_addr];
  end

  always_comb begin
    sr_d     = sr_q;
    sc_d     = sc_q;
    dir_d    = dir_q;
    sweeps_d = sweeps_q;
    chg_d    = chg_q;
    ovf_d    = ovf_q;
    if (cmd_i.do_write) begin
      ovf_d = in_grid && item_ovf;
    end
    if (cmd_i.nb_wr && sum[HeightBits]) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.sw_start) begin
      sr_d     = RowW'(1);
      sc_d     = ColW'(1);
      sweeps_d = sweeps_q + 20'd1;
      chg_d    = 1'b0;
    end
    if (cmd_i.div_start) begin
      chg_d = 1'b1;
      dir_d = nd_first[2:0];
    end
    if (cmd_i.nb_wr) begin
      dir_d = nd_after[2:0];
    end
    if (cmd_i.scan_next) begin
      if ({1'b0, sc_q} + 9'd2 >= nc) begin
        sc_d = ColW'(1);
        sr_d = sr_q + 1'b1;
      end else begin
        sc_d = sc_q + 1'b1;
      end
    end
    if (cmd_i.zr_start) begin
      sr_d = '0;
      sc_d = '0;
    end
    if (cmd_i.zr_wr) begin
      if ({1'b0, sc_q} + 9'd1 >= nc) begin
        sc_d = '0;
        sr_d = sr_q + 1'b1;
      end else begin
        sc_d = sc_q + 1'b1;
      end
    end
    if (cmd_i.cap_item) begin
      sweeps_d = '0;
      chg_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= RowsReset;
      cols_q   <= ColsReset;
      limit_q  <= LimitReset;
      ovf_q    <= 1'b0;
      sweeps_q <= '0;
      chg_q    <= 1'b0;
      sr_q     <= '0;
      sc_q     <= '0;
      dir_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRows:  rows_q  <= cfg_data_i[5:0];
          CfgCols:  cols_q  <= cfg_data_i[5:0];
          CfgLimit: limit_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      ovf_q    <= ovf_d;
      sweeps_q <= sweeps_d;
      chg_q    <= chg_d;
      sr_q     <= sr_d;
      sc_q     <= sc_d;
      dir_q    <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) item_q <= in_word_i;
    if (cmd_i.cell_rd) cur_attr_q <= amem[cur_addr];
    if (div_done) begin
      pile_q <= quot;
      rem_q  <= rem;
    end
  end

  // result word
  logic [19:0] lim_eff;
  assign lim_eff = (limit_q == 20'd0) ? 20'd1 : limit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_relax) begin
      out_word_o.cell_height <= '0;
      out_word_o.sweeps_done <= sweeps_q;
      out_word_o.not_stable  <= chg_q;
      out_word_o.overflow    <= ovf_q;
    end else if (cmd_i.res_other) begin
      out_word_o.cell_height <= '0;
      if (item_q.kind == KindRead && in_grid) begin
        out_word_o.cell_height <= (HeightBits > 32 && (rd_h_q >> 32) != '0) ?
                                  32'hFFFF_FFFF : 32'(rd_h_q);
      end
      out_word_o.sweeps_done <= '0;
      out_word_o.not_stable  <= 1'b0;
      out_word_o.overflow    <= ovf_q;
    end
  end

  assign sts_o.topple      = !cur_attr_q.sink && (cur_attr_q.degree != 6'd0) &&
                             (rd_h_q >= HeightBits'(cur_attr_q.degree));
  assign sts_o.div_done    = div_done;
  assign sts_o.nb_first    = !nd_first[3];
  assign sts_o.nb_any      = !nd_after[3];
  assign sts_o.scan_last   = ({1'b0, sr_q} + 9'd2 >= nr) && ({1'b0, sc_q} + 9'd2 >= nc);
  assign sts_o.no_interior = (nr < 9'd3) || (nc < 9'd3);
  assign sts_o.no_cells    = (nr == 9'd0) || (nc == 9'd0);
  assign sts_o.zr_last     = ({1'b0, sr_q} + 9'd1 >= nr) && ({1'b0, sc_q} + 9'd1 >= nc);
  assign sts_o.sweep_more  = chg_q && (sweeps_q < lim_eff);
endmodule

### sv/srs_ctrl.sv
// Controller: sequences write, read and relax items over the datapath.
`timescale 1ns / 1ps
`include "sandpile_relax_irregular_marked_sink_defines.svh"
module srs_ctrl import srs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [1:0] in_kind_i,
  output logic     out_valid,
  input  logic     out_stall,
  input  sts_t     sts_i,
  output cmd_t     cmd_o
);
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StExec   = 4'd1;
  localparam logic [3:0] StRdWait = 4'd2;
  localparam logic [3:0] StSweep  = 4'd3;
  localparam logic [3:0] StCellRd = 4'd4;
  localparam logic [3:0] StCellEv = 4'd5;
  localparam logic [3:0] StDiv    = 4'd6;
  localparam logic [3:0] StNbRd   = 4'd7;
  localparam logic [3:0] StNbWr   = 4'd8;
  localparam logic [3:0] StSelfWr = 4'd9;
  localparam logic [3:0] StNext   = 4'd10;
  localparam logic [3:0] StZrRd   = 4'd11;
  localparam logic [3:0] StZrWr   = 4'd12;
  localparam logic [3:0] StDone   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q;
  logic       ovld_q, ovld_d;
  logic       accept;
  // first direction valid: captured when division starts
  logic       dir_valid_q;

  // a held result only blocks the block once the next result is ready
  assign in_stall  = (state_q != StIdle);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovld_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ovld_d  = ovld_q && out_stall;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.cap_item = 1'b1;
          state_d = StExec;
        end
      end
      StExec: begin
        if (kind_q == KindWrite) begin
          cmd_o.do_write  = 1'b1;
          state_d = StDone;
        end else if (kind_q == KindRelax) begin
          state_d = StSweep;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = StRdWait;
        end
      end
      StRdWait: begin
        // keep the read data on the item cell until the result is built
        cmd_o.rd_issue = 1'b1;
        state_d = StDone;
      end
      StSweep: begin
        cmd_o.sw_start = 1'b1;
        state_d = sts_i.no_interior ? StNext : StCellRd;
      end
      StCellRd: begin
        cmd_o.cell_rd = 1'b1;
        state_d = StCellEv;
      end
      StCellEv: begin
        if (sts_i.topple) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StNext;
        end
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StSelfWr;
      end
      StSelfWr: begin
        // remainder first: neighbors never alias the cell itself
        cmd_o.self_wr = 1'b1;
        state_d = dir_valid_q ? StNbRd : StNext;
      end
      StNbRd: begin
        cmd_o.nb_rd = 1'b1;
        state_d = StNbWr;
      end
      StNbWr: begin
        cmd_o.nb_wr = 1'b1;
        state_d = sts_i.nb_any ? StNbRd : StNext;
      end
      StNext: begin
        if (sts_i.no_interior || sts_i.scan_last) begin
          if (sts_i.sweep_more) begin
            state_d = StSweep;
          end else if (sts_i.no_cells) begin
            state_d = StDone;
          end else begin
            cmd_o.zr_start = 1'b1;
            state_d = StZrRd;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d = StCellRd;
        end
      end
      StZrRd: begin
        cmd_o.zr_rd = 1'b1;
        state_d = StZrWr;
      end
      StZrWr: begin
        cmd_o.zr_wr = 1'b1;
        state_d = sts_i.zr_last ? StDone : StZrRd;
      end
      StDone: begin
        cmd_o.rd_issue = 1'b1;
        if (!(ovld_q && out_stall)) begin
          if (kind_q == KindRelax) cmd_o.res_relax = 1'b1;
          else cmd_o.res_other = 1'b1;
          ovld_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ovld_q      <= 1'b0;
      kind_q      <= KindWrite;
      dir_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (accept) kind_q <= in_kind_i;
      if (cmd_o.div_start) dir_valid_q <= sts_i.nb_first;
    end
  end

  `SRS_ASSERT_IMP(a_busy_stalls, clk_i, rst_ni, state_q != StIdle, in_stall, "busy but not stalling")
  `SRS_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, accept, state_q == StExec, "accept lost")
  `SRS_ASSERT_IMP(a_one_wr, clk_i, rst_ni, cmd_o.nb_wr, !cmd_o.self_wr && !cmd_o.do_write, "double write")
endmodule

### sv/sandpile_relax_irregular_marked_sink.sv
// Sandpile relaxation top level: write, read and relax a directed grid of cells.
// A write word writes its cell and a read word reads it before the result is built.
// A relax starts each sweep, then reads and evaluates each interior cell; a toppling
// cell runs through the bit-serial divider, writes its remainder and then feeds each
// selected neighbor with a read and a write. After the last sweep a zeroing pass
// clears each sink or degree-zero cell in use, and then the result is built. A result
// held by out_stall does not hold off the next word; only the following result waits.
`timescale 1ns / 1ps
module sandpile_relax_irregular_marked_sink import srs_pkg::*; #(
  parameter int unsigned MaxRows    = MaxRowsDef,
  parameter int unsigned MaxCols    = MaxColsDef,
  parameter int unsigned HeightBits = HeightBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  srs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid, .in_stall,
    .in_kind_i(in_data_i.kind),
    .out_valid, .out_stall,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  srs_datapath #(
    .MaxRows(MaxRows), .MaxCols(MaxCols), .HeightBits(HeightBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .in_word_i (in_data_i),
    .cfg_we_i  (cfg_valid),
    .cfg_idx_i (cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_word_o(out_data_o)
  );
endmodule
